FILE: hw/rtl/sha256_message_hasher_top_defines.svh
// Assertion macros for the checker file.
`ifndef SHA256_MESSAGE_HASHER_TOP_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SHA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sha256_pkg.sv
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } msg_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } hash_t;

    // byte source for the block shift register
    localparam logic [1:0] BYTE_DATA = 2'd0;
    localparam logic [1:0] BYTE_PAD  = 2'd1;
    localparam logic [1:0] BYTE_ZERO = 2'd2;
    localparam logic [1:0] BYTE_LEN  = 2'd3;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    typedef struct packed {
        logic       shift_byte;
        logic [1:0] byte_sel;
        logic       count_bits;
        logic       load_work;
        logic       round;
        logic [5:0] round_idx;
        logic       add_hash;
        logic       restart;
        logic [2:0] word_sel;
    } dp_cmd_t;

    localparam logic [0:7][31:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

FILE: hw/rtl/sha256_ctrl.sv
module sha256_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    output logic                msg_stall,
    input  sha256_pkg::msg_t    msg,
    output logic                hash_valid,
    input  logic                hash_stall,
    output sha256_pkg::dp_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_INIT  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] fill_reg, fill_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] word_reg, word_next;
    logic       pad_reg, pad_next;      // message closing, padding in progress
    logic       first_reg, first_next;  // 0x80 still to be placed
    logic       len_reg, len_next;      // length bytes being placed

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        round_next = round_reg;
        word_next  = word_reg;
        pad_next   = pad_reg;
        first_next = first_reg;
        len_next   = len_reg;

        cmd           = '0;
        cmd.byte_sel  = sha256_pkg::BYTE_DATA;
        cmd.round_idx = round_reg;
        cmd.word_sel  = word_reg;

        msg_stall  = (state_reg != S_IDLE);
        hash_valid = (state_reg == S_EMIT);

        unique case (state_reg)
            S_IDLE:
            begin
                if (msg_valid)
                begin
                    if (msg.has_byte)
                    begin
                        cmd.shift_byte = 1'b1;
                        cmd.count_bits = 1'b1;
                        fill_next      = fill_reg + 6'd1;
                    end
                    if (msg.end_of_message)
                    begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                    end
                    if (msg.has_byte && fill_reg == sha256_pkg::LAST_POS)
                        state_next = S_INIT;
                    else if (msg.end_of_message)
                        state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                cmd.shift_byte = 1'b1;
                fill_next      = fill_reg + 6'd1;
                if (first_reg)
                begin
                    cmd.byte_sel = sha256_pkg::BYTE_PAD;
                    first_next   = 1'b0;
                end
                else if (len_reg || fill_reg == sha256_pkg::LEN_POS)
                begin
                    cmd.byte_sel = sha256_pkg::BYTE_LEN;
                    len_next     = 1'b1;
                end
                else
                begin
                    cmd.byte_sel = sha256_pkg::BYTE_ZERO;
                end
                if (fill_reg == sha256_pkg::LAST_POS)
                    state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.load_work = 1'b1;
                round_next    = '0;
                state_next    = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == sha256_pkg::LAST_ROUND)
                    state_next = S_FINAL;
            end
            S_FINAL:
            begin
                cmd.add_hash = 1'b1;
                if (len_reg)
                begin
                    word_next  = '0;
                    state_next = S_EMIT;
                end
                else if (pad_reg)
                    state_next = S_PAD;
                else
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (!hash_stall)
                begin
                    word_next = word_reg + 3'd1;
                    if (word_reg == sha256_pkg::LAST_WORD)
                    begin
                        cmd.restart = 1'b1;
                        pad_next    = 1'b0;
                        len_next    = 1'b0;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            round_reg <= '0;
            word_reg  <= '0;
            pad_reg   <= 1'b0;
            first_reg <= 1'b0;
            len_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            round_reg <= round_next;
            word_reg  <= word_next;
            pad_reg   <= pad_next;
            first_reg <= first_next;
            len_reg   <= len_next;
        end
    end

endmodule

FILE: hw/rtl/sha256_dp.sv
module sha256_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  sha256_pkg::dp_cmd_t cmd,
    output logic [31:0]         digest_word
);

    // 512-bit block window: bytes shift in at the bottom, then it serves as
    // the 16-word message schedule during the rounds (word 0 at the top).
    logic [511:0]          sched_reg, sched_next;
    logic [0:7][31:0]      work_reg, work_next;
    logic [0:7][31:0]      hash_reg, hash_next;
    logic [63:0]           bits_reg, bits_next;

    logic [7:0]  byte_in;
    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] sum1, sum2;

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    assign w0  = sched_reg[511:480];
    assign w1  = sched_reg[479:448];
    assign w9  = sched_reg[223:192];
    assign w14 = sched_reg[63:32];
    assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;

    assign sum1 = work_reg[7] + bsig1(work_reg[4])
                + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
                + sha256_pkg::ROUND_K[cmd.round_idx] + w0;
    assign sum2 = bsig0(work_reg[0])
                + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                   ^ (work_reg[1] & work_reg[2]));

    always_comb
    begin
        case (cmd.byte_sel)
            sha256_pkg::BYTE_DATA: byte_in = data_byte;
            sha256_pkg::BYTE_PAD:  byte_in = sha256_pkg::PAD_BYTE;
            sha256_pkg::BYTE_LEN:  byte_in = bits_reg[63:56];
            default:               byte_in = 8'd0;
        endcase
    end

    always_comb
    begin
        sched_next = sched_reg;
        work_next  = work_reg;
        hash_next  = hash_reg;
        bits_next  = bits_reg;

        if (cmd.shift_byte)
            sched_next = {sched_reg[503:0], byte_in};
        else if (cmd.round)
            sched_next = {sched_reg[479:0], w_new};

        if (cmd.load_work)
            work_next = hash_reg;
        else if (cmd.round)
        begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + sum1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = sum1 + sum2;
        end

        if (cmd.restart)
            hash_next = sha256_pkg::H_INIT;
        else if (cmd.add_hash)
        begin
            for (int i = 0; i < 8; i++)
                hash_next[i] = hash_reg[i] + work_reg[i];
        end

        if (cmd.restart)
            bits_next = '0;
        else if (cmd.count_bits)
            bits_next = bits_reg + 64'd8;
        else if (cmd.shift_byte && cmd.byte_sel == sha256_pkg::BYTE_LEN)
            bits_next = {bits_reg[55:0], 8'd0};
    end

    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
        work_reg  <= work_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= sha256_pkg::H_INIT;
            bits_reg <= '0;
        end
        else
        begin
            hash_reg <= hash_next;
            bits_reg <= bits_next;
        end
    end

    assign digest_word = hash_reg[cmd.word_sel];

endmodule

FILE: hw/rtl/sha256_message_hasher_top.sv
// SHA-256 over a byte stream. Each msg transaction carries at most one byte
// and may close the message. Every 64th byte starts a compression (load,
// 64 rounds on a single shared round unit at one round per cycle, chaining
// add). Closing a message places the padding and the 64-bit length one
// byte per cycle into the block window, with one or two compressions, and
// then presents the eight digest words as eight hash transactions, word 0
// (most significant) first. msg_stall is high through each compression,
// and from the start of padding until the last digest word is taken; the
// hasher then starts over from the initial value.
module sha256_message_hasher_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    output logic                msg_stall,
    input  sha256_pkg::msg_t    msg,
    output logic                hash_valid,
    input  logic                hash_stall,
    output sha256_pkg::hash_t   hash
);

    sha256_pkg::dp_cmd_t cmd;
    logic [31:0]         digest_word;

    sha256_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_valid  (msg_valid),
        .msg_stall  (msg_stall),
        .msg        (msg),
        .hash_valid (hash_valid),
        .hash_stall (hash_stall),
        .cmd        (cmd)
    );

    sha256_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (msg.data_byte),
        .cmd         (cmd),
        .digest_word (digest_word)
    );

    assign hash.digest_word = digest_word;
    assign hash.word_index  = cmd.word_sel;
    assign hash.last_word   = (cmd.word_sel == sha256_pkg::LAST_WORD);

endmodule

FILE: hw/rtl/sha256_checker.sv
`include "sha256_message_hasher_top_defines.svh"

module sha256_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              msg_valid,
    input logic              msg_stall,
    input sha256_pkg::msg_t  msg,
    input logic              hash_valid,
    input logic              hash_stall,
    input sha256_pkg::hash_t hash
);

    `SHA_ASSERT_NEXT(a_hash_hold, hash_valid && hash_stall, hash_valid && $stable(hash), "stalled digest word changed")
    `SHA_ASSERT_NOW(a_no_input_while_emit, hash_valid, msg_stall, "msg taken while digest is out")
    `SHA_ASSERT_NOW(a_first_word, $rose(hash_valid), hash.word_index == 3'd0, "digest does not start at word 0")
    `SHA_ASSERT_NEXT(a_word_order, hash_valid && !hash_stall && !hash.last_word, hash_valid && hash.word_index == $past(hash.word_index) + 3'd1, "digest words out of order")
    `SHA_ASSERT_NEXT(a_end_after_last, hash_valid && !hash_stall && hash.last_word, !hash_valid, "extra digest word after last")

endmodule

bind sha256_message_hasher_top sha256_checker u_sha256_checker (.*);
